// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define USG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define USG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/usg_pkg.sv -----
// Package of the UV-sphere vertex generator: widths, types, sine table and helpers.
`default_nettype none
package usg_pkg;

  localparam int IDX_W    = 8;
  localparam int CNT_W    = 9;
  localparam int RAD_W    = 16;
  localparam int TEX_FRAC = 16;
  localparam int QUO_W    = IDX_W + TEX_FRAC;
  localparam int DIV_STEPS = QUO_W;
  localparam int PH_W     = 10;
  localparam int LUT_N    = 256;

  typedef logic [15:0] sin_lut_t [LUT_N];

  typedef struct packed {
    logic             neg;
    logic [15:0]      mag;
  } trig_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] ring;
    logic [IDX_W-1:0] sector;
    logic [QUO_W-1:0] quo_r;
    logic [IDX_W-1:0] rem_r;
    logic [QUO_W-1:0] quo_s;
    logic [IDX_W-1:0] rem_s;
  } div_res_t;

  function automatic logic [15:0] sine_mag_calc(int k);
    longint unsigned x;
    longint unsigned z2;
    longint unsigned acc;
    longint unsigned res;
    x   = longint'(k) << 22;
    z2  = (x * x) >> 30;
    acc = 64'd172272;
    acc = 64'd5026995 - ((acc * z2) >> 30);
    acc = 64'd85569306 - ((acc * z2) >> 30);
    acc = 64'd693598668 - ((acc * z2) >> 30);
    acc = 64'd1686629713 - ((acc * z2) >> 30);
    res = (acc * x) >> 30;
    res = (res + 64'd16384) >> 15;
    if (res > 64'd32768) res = 64'd32768;
    return res[15:0];
  endfunction

  function automatic sin_lut_t build_sin_lut();
    sin_lut_t lut;
    for (int k = 0; k < LUT_N; k++) lut[k] = sine_mag_calc(k);
    return lut;
  endfunction

  localparam sin_lut_t    SIN_LUT  = build_sin_lut();
  localparam logic [15:0] SIN_PEAK = sine_mag_calc(LUT_N);

  // sine of a phase in 1/1024 turns, folded into the first quarter
  function automatic trig_t trig_lookup(logic [PH_W-1:0] ph);
    trig_t      t;
    logic [8:0] kf;
    kf = ph[8] ? (9'd256 - {1'b0, ph[7:0]}) : {1'b0, ph[7:0]};
    t.neg = ph[9];
    t.mag = kf[8] ? SIN_PEAK : SIN_LUT[kf[7:0]];
    return t;
  endfunction

  // one restoring division step: {quotient bit, remainder}
  function automatic logic [IDX_W:0] div_step(logic [IDX_W-1:0] rem, logic nb,
                                              logic [IDX_W-1:0] dv);
    logic [IDX_W:0] t;
    logic [IDX_W:0] d;
    t = {rem, nb};
    d = t - {1'b0, dv};
    if (t >= {1'b0, dv}) return {1'b1, d[IDX_W-1:0]};
    else return {1'b0, t[IDX_W-1:0]};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/usg_div.sv -----
// Pipelined restoring divider: ring and sector index times 2^16 over count minus one.
`default_nettype none
module usg_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [usg_pkg::IDX_W-1:0]   ring_i,
  input  wire logic [usg_pkg::IDX_W-1:0]   sector_i,
  input  wire logic [usg_pkg::IDX_W-1:0]   div_r_i,
  input  wire logic [usg_pkg::IDX_W-1:0]   div_s_i,
  output usg_pkg::div_res_t                res_o
);

  localparam int N  = usg_pkg::DIV_STEPS;
  localparam int IW = usg_pkg::IDX_W;
  localparam int QW = usg_pkg::QUO_W;

  logic          vld_q   [N];
  logic [IW-1:0] ring_q  [N];
  logic [IW-1:0] sect_q  [N];
  logic [IW-1:0] rem_r_q [N];
  logic [IW-1:0] rem_s_q [N];
  logic [QW-1:0] quo_r_q [N];
  logic [QW-1:0] quo_s_q [N];

  logic [IW:0] st0_r, st0_s;
  logic [IW:0] st_r [N];
  logic [IW:0] st_s [N];

  always_comb begin
    st0_r = usg_pkg::div_step('0, ring_i[IW-1], div_r_i);
    st0_s = usg_pkg::div_step('0, sector_i[IW-1], div_s_i);
    st_r[0] = st0_r;
    st_s[0] = st0_s;
    for (int i = 1; i < N; i++) begin
      st_r[i] = usg_pkg::div_step(rem_r_q[i-1],
                  (i < IW) ? ring_q[i-1][3'(IW-1-i)] : 1'b0, div_r_i);
      st_s[i] = usg_pkg::div_step(rem_s_q[i-1],
                  (i < IW) ? sect_q[i-1][3'(IW-1-i)] : 1'b0, div_s_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < N; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ring_q[0]  <= ring_i;
      sect_q[0]  <= sector_i;
      rem_r_q[0] <= st_r[0][IW-1:0];
      rem_s_q[0] <= st_s[0][IW-1:0];
      quo_r_q[0] <= QW'(st_r[0][IW]);
      quo_s_q[0] <= QW'(st_s[0][IW]);
      for (int i = 1; i < N; i++) begin
        ring_q[i]  <= ring_q[i-1];
        sect_q[i]  <= sect_q[i-1];
        rem_r_q[i] <= st_r[i][IW-1:0];
        rem_s_q[i] <= st_s[i][IW-1:0];
        quo_r_q[i] <= {quo_r_q[i-1][QW-2:0], st_r[i][IW]};
        quo_s_q[i] <= {quo_s_q[i-1][QW-2:0], st_s[i][IW]};
      end
    end
  end

  assign res_o.valid  = vld_q[N-1];
  assign res_o.ring   = ring_q[N-1];
  assign res_o.sector = sect_q[N-1];
  assign res_o.quo_r  = quo_r_q[N-1];
  assign res_o.rem_r  = rem_r_q[N-1];
  assign res_o.quo_s  = quo_s_q[N-1];
  assign res_o.rem_s  = rem_s_q[N-1];

endmodule
`default_nettype wire

// ----- rtl/uv_sphere_vertex_generator.sv -----
// Top level of the UV-sphere vertex generator.
//
//  channel | signals                              | handshake
//  --------+--------------------------------------+-----------------------
//  input   | ring_index_i, sector_index_i         | in_valid_i / in_ready_o
//  output  | pos_*, norm_*, tex_*, quad_*         | out_valid_o / out_ready_i
//  config  | cfg_idx_i, cfg_data_i                | cfg_we_i, no wait
//
// One item per cycle while the pipeline is not halted; the stages are 24 divider
// steps, phase, sine table, normal multiply, position multiply and output queue.
// A two-entry output queue keeps the pipeline moving while a result waits;
// the pipeline halts only when the queue is full and not being drained.
// Reset clears valid bits and loads radius 1.0 and 16 rings and sectors.
`default_nettype none
`include "assert_macros.svh"
module uv_sphere_vertex_generator (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [7:0]            ring_index_i,
  input  wire logic [7:0]            sector_index_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic signed [16:0]         pos_x_o,
  output logic signed [16:0]         pos_y_o,
  output logic signed [16:0]         pos_z_o,
  output logic signed [15:0]         norm_x_o,
  output logic signed [15:0]         norm_y_o,
  output logic signed [15:0]         norm_z_o,
  output logic [16:0]                tex_u_o,
  output logic [16:0]                tex_v_o,
  output logic [15:0]                quad_base_o,
  output logic                       quad_valid_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [15:0]           cfg_data_i
);

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_RINGS  = 2'd1;
  localparam logic [1:0] REG_SECTS  = 2'd2;

  localparam int IW = usg_pkg::IDX_W;
  localparam int CW = usg_pkg::CNT_W;
  localparam int QW = usg_pkg::QUO_W;
  localparam int PW = usg_pkg::PH_W;
  localparam int TF = usg_pkg::TEX_FRAC;
  localparam logic [16:0] TEX_ONE = 17'(1 << TF);

  typedef struct packed {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [15:0]        quad_base;
    logic               quad_valid;
  } out_t;

  typedef struct packed {
    logic        neg;
    logic [16:0] mag;
  } smag_t;

  function automatic logic [CW-1:0] clamp_count(logic [CW-1:0] v);
    if (v < CW'(2)) return CW'(2);
    else if (v > CW'(256)) return CW'(256);
    else return v;
  endfunction

  function automatic logic signed [16:0] to_signed17(smag_t v);
    return v.neg ? -$signed(v.mag) : $signed(v.mag);
  endfunction

  function automatic logic signed [15:0] sat_norm(smag_t v);
    logic signed [16:0] s;
    s = to_signed17(v);
    if (!v.neg && v.mag > 17'd32767) return 16'sd32767;
    else return s[15:0];
  endfunction

  // configuration
  logic [15:0]   radius_q;
  logic [CW-1:0] rcnt_q, scnt_q;
  logic [IW-1:0] rdiv, sdiv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      rcnt_q   <= CW'(16);
      scnt_q   <= CW'(16);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RADIUS: radius_q <= cfg_data_i;
        REG_RINGS:  rcnt_q   <= clamp_count(cfg_data_i[CW-1:0]);
        REG_SECTS:  scnt_q   <= clamp_count(cfg_data_i[CW-1:0]);
        default: ;
      endcase
    end
  end

  logic [CW-1:0] rdiv_w, sdiv_w;
  assign rdiv_w = rcnt_q - CW'(1);
  assign sdiv_w = scnt_q - CW'(1);
  assign rdiv   = rdiv_w[IW-1:0];
  assign sdiv   = sdiv_w[IW-1:0];

  // flow control
  logic [1:0] cnt_q;
  logic       en, push, pop;
  logic       d_vld_q;

  assign pop        = out_valid_o && out_ready_i;
  assign en         = (cnt_q != 2'd2) || out_ready_i;
  assign push       = en && d_vld_q;
  assign in_ready_o = en;

  // divider
  usg_pkg::div_res_t dres;

  usg_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .ring_i   (ring_index_i),
    .sector_i (sector_index_i),
    .div_r_i  (rdiv),
    .div_s_i  (sdiv),
    .res_o    (dres)
  );

  // stage A: phases, texture coordinates, quad index
  logic [QW:0]   ps_sum, qs_sum;
  logic          rb_s, rb_r;
  logic [16:0]   tu_d, tv_d;
  logic [IW+CW-1:0] base_w;

  assign ps_sum = {1'b0, dres.quo_s} + (QW+1)'(1 << (TF - PW - 1));
  assign qs_sum = {1'b0, dres.quo_r} + (QW+1)'(1 << (TF - PW));
  assign rb_s   = {dres.rem_s, 1'b0} >= {1'b0, sdiv};
  assign rb_r   = {dres.rem_r, 1'b0} >= {1'b0, rdiv};
  assign tu_d   = (dres.quo_s >= QW'(TEX_ONE)) ? TEX_ONE :
                  (17'(dres.quo_s) + 17'(rb_s));
  assign tv_d   = (dres.quo_r >= QW'(TEX_ONE)) ? TEX_ONE :
                  (17'(dres.quo_r) + 17'(rb_r));
  assign base_w = (IW+CW)'(dres.ring) * (IW+CW)'(scnt_q) + (IW+CW)'(dres.sector);

  logic          a_vld_q, b_vld_q, c_vld_q;
  logic [PW-1:0] a_p_q, a_q_q;
  logic [16:0]   a_tu_q, a_tv_q, b_tu_q, b_tv_q, c_tu_q, c_tv_q;
  logic [15:0]   a_base_q, b_base_q, c_base_q;
  logic          a_qv_q, b_qv_q, c_qv_q;

  // stage B: sine table
  usg_pkg::trig_t b_st_q, b_ct_q, b_sp_q, b_cp_q;

  // stage C: normals
  smag_t c_n0_q, c_n1_q, c_n2_q;
  logic [33:0] prod0, prod2;

  assign prod0 = 34'(b_ct_q.mag) * 34'(b_sp_q.mag) + 34'd16384;
  assign prod2 = 34'(b_st_q.mag) * 34'(b_sp_q.mag) + 34'd16384;

  // stage D: positions
  out_t        d_q;
  logic [33:0] pm0, pm1, pm2;

  assign pm0 = 34'(c_n0_q.mag) * 34'(radius_q) + 34'd16384;
  assign pm1 = 34'(c_n1_q.mag) * 34'(radius_q) + 34'd16384;
  assign pm2 = 34'(c_n2_q.mag) * 34'(radius_q) + 34'd16384;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= dres.valid;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_p_q    <= ps_sum[TF-1 -: PW];
      a_q_q    <= qs_sum[TF -: PW];
      a_tu_q   <= tu_d;
      a_tv_q   <= tv_d;
      a_base_q <= base_w[15:0];
      a_qv_q   <= (dres.ring < rdiv) && (dres.sector < sdiv);

      b_st_q   <= usg_pkg::trig_lookup(a_p_q);
      b_ct_q   <= usg_pkg::trig_lookup(a_p_q + PW'(256));
      b_sp_q   <= usg_pkg::trig_lookup(a_q_q);
      b_cp_q   <= usg_pkg::trig_lookup(a_q_q + PW'(256));
      b_tu_q   <= a_tu_q;
      b_tv_q   <= a_tv_q;
      b_base_q <= a_base_q;
      b_qv_q   <= a_qv_q;

      c_n0_q   <= '{neg: b_ct_q.neg ^ b_sp_q.neg, mag: prod0[31:15]};
      c_n1_q   <= '{neg: !b_cp_q.neg, mag: {1'b0, b_cp_q.mag}};
      c_n2_q   <= '{neg: b_st_q.neg ^ b_sp_q.neg, mag: prod2[31:15]};
      c_tu_q   <= b_tu_q;
      c_tv_q   <= b_tv_q;
      c_base_q <= b_base_q;
      c_qv_q   <= b_qv_q;

      d_q.pos_x      <= to_signed17('{neg: c_n0_q.neg, mag: pm0[31:15]});
      d_q.pos_y      <= to_signed17('{neg: c_n1_q.neg, mag: pm1[31:15]});
      d_q.pos_z      <= to_signed17('{neg: c_n2_q.neg, mag: pm2[31:15]});
      d_q.norm_x     <= sat_norm(c_n0_q);
      d_q.norm_y     <= sat_norm(c_n1_q);
      d_q.norm_z     <= sat_norm(c_n2_q);
      d_q.tex_u      <= c_tu_q;
      d_q.tex_v      <= c_tv_q;
      d_q.quad_base  <= c_base_q;
      d_q.quad_valid <= c_qv_q;
    end
  end

  // output queue
  out_t fifo_q [2];
  logic wp_q, rp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= d_q;
  end

  out_t head;
  assign head         = fifo_q[rp_q];
  assign out_valid_o  = cnt_q != 2'd0;
  assign pos_x_o      = head.pos_x;
  assign pos_y_o      = head.pos_y;
  assign pos_z_o      = head.pos_z;
  assign norm_x_o     = head.norm_x;
  assign norm_y_o     = head.norm_y;
  assign norm_z_o     = head.norm_z;
  assign tex_u_o      = head.tex_u;
  assign tex_v_o      = head.tex_v;
  assign quad_base_o  = head.quad_base;
  assign quad_valid_o = head.quad_valid;

  `USG_ASSERT_ALWAYS(a_cnt_bound, !rst_ni || cnt_q != 2'd3, "output queue count out of range")
  `USG_ASSERT(a_no_overflow, !(push && !pop && cnt_q == 2'd2), "output queue overflow")
  `USG_ASSERT(a_quad_tex, (out_valid_o && quad_valid_o) |-> (tex_u_o != TEX_ONE && tex_v_o != TEX_ONE), "quad flagged at grid edge")

endmodule
`default_nettype wire

// ----- bench/tb_uv_sphere_vertex_generator.sv -----
// Self-checking testbench of the UV-sphere vertex generator: directed and random grid points.
`timescale 1ns / 100ps
`default_nettype none
module tb_uv_sphere_vertex_generator;

  localparam int PHASE_STEPS = 1024;
  localparam int MAX_CNT     = 256;
  localparam int LATENCY     = 29;

  typedef enum logic [1:0] {
    REG_RADIUS  = 2'd0,
    REG_RINGS   = 2'd1,
    REG_SECTORS = 2'd2,
    REG_SPARE   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic signed [16:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [15:0]        quad_base;
    logic               quad_valid;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] ring_index_i = '0;
  logic [7:0] sector_index_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [16:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [15:0] norm_x_o, norm_y_o, norm_z_o;
  logic [16:0] tex_u_o, tex_v_o;
  logic [15:0] quad_base_o;
  logic quad_valid_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  longint unsigned radius_q88;
  longint unsigned rings_cfg;
  longint unsigned sectors_cfg;
  vertex_t pending_vertices[$];
  int errors = 0;
  int sent_items = 0;
  int got_items = 0;
  bit hold_off = 1'b0;

  always #4 clk_i = ~clk_i;

  uv_sphere_vertex_generator DUT (.*);

  function automatic longint sine_q15(longint unsigned turn);
    longint unsigned quad, x, z2, acc, res;
    quad = (turn >> 30) & 3;
    x = turn & 64'h3FFF_FFFF;
    if (quad[0]) x = 64'd1073741824 - x;
    z2 = (x * x) >> 30;
    acc = 64'd172272;
    acc = 64'd5026995 - ((acc * z2) >> 30);
    acc = 64'd85569306 - ((acc * z2) >> 30);
    acc = 64'd693598668 - ((acc * z2) >> 30);
    acc = 64'd1686629713 - ((acc * z2) >> 30);
    res = (acc * x) >> 30;
    res = (res + 64'd16384) >> 15;
    if (res > 64'd32768) res = 64'd32768;
    return quad[1] ? -longint'(res) : longint'(res);
  endfunction

  function automatic longint scale_round(longint a, longint b, int sh);
    longint unsigned ma, mb, m;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    m = (ma * mb + (64'd1 << (sh - 1))) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned tex_coord(longint unsigned idx, longint unsigned dv);
    longint unsigned t;
    t = (2 * idx * 65536 + dv) / (2 * dv);
    return t > 65536 ? 65536 : t;
  endfunction

  function automatic vertex_t sphere_vertex(logic [7:0] ring, logic [7:0] sector);
    vertex_t v;
    longint unsigned rc, sc, p, q, tu, tv;
    longint sin_t, cos_t, sin_p, cos_p, nx, ny, nz;
    rc = rings_cfg < 2 ? 2 : (rings_cfg > MAX_CNT ? MAX_CNT : rings_cfg);
    sc = sectors_cfg < 2 ? 2 : (sectors_cfg > MAX_CNT ? MAX_CNT : sectors_cfg);
    p = ((2 * sector * PHASE_STEPS + (sc - 1)) / (2 * (sc - 1))) % PHASE_STEPS;
    q = ((ring * PHASE_STEPS + (rc - 1)) / (2 * (rc - 1))) % PHASE_STEPS;
    tu = ((p << 32) + PHASE_STEPS / 2) / PHASE_STEPS;
    tv = ((q << 32) + PHASE_STEPS / 2) / PHASE_STEPS;
    sin_t = sine_q15(tu);
    cos_t = sine_q15((tu + 64'h4000_0000) & 64'hFFFF_FFFF);
    sin_p = sine_q15(tv);
    cos_p = sine_q15((tv + 64'h4000_0000) & 64'hFFFF_FFFF);
    nx = scale_round(cos_t, sin_p, 15);
    ny = -cos_p;
    nz = scale_round(sin_t, sin_p, 15);
    v.pos_x = 17'(scale_round(nx, radius_q88, 15));
    v.pos_y = 17'(scale_round(ny, radius_q88, 15));
    v.pos_z = 17'(scale_round(nz, radius_q88, 15));
    v.norm_x = 16'(nx > 32767 ? 32767 : nx);
    v.norm_y = 16'(ny > 32767 ? 32767 : ny);
    v.norm_z = 16'(nz > 32767 ? 32767 : nz);
    v.tex_u = 17'(tex_coord(sector, sc - 1));
    v.tex_v = 17'(tex_coord(ring, rc - 1));
    v.quad_base = 16'(ring * sc + sector);
    v.quad_valid = (ring < rc - 1) && (sector < sc - 1);
    return v;
  endfunction

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // valid stays high after an accept; a gap before the next item or drain() takes it down
  task automatic send_point(logic [7:0] ring, logic [7:0] sector, bit gaps);
    int gap;
    gap = gaps ? gap_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ring_index_i <= ring;
    sector_index_i <= sector;
    pending_vertices = {pending_vertices, sphere_vertex(ring, sector)};
    sent_items++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (pending_vertices.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_RADIUS:  radius_q88 = data;
      REG_RINGS:   rings_cfg = data[8:0];
      REG_SECTORS: sectors_cfg = data[8:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_shape(logic [15:0] rad, logic [15:0] rings, logic [15:0] sectors);
    drain();
    write_reg(REG_RADIUS, rad);
    write_reg(REG_RINGS, rings);
    write_reg(REG_SECTORS, sectors);
  endtask

  task automatic test_reset_grid();
    for (int r = 0; r < 16; r += 5)
      for (int s = 0; s < 16; s += 5) send_point(8'(r), 8'(s), 1'b0);
    send_point(8'd15, 8'd15, 1'b0);
  endtask

  task automatic test_field_extremes();
    set_shape(16'hFFFF, 16'd256, 16'd256);
    send_point(8'd0, 8'd0, 1'b0);
    send_point(8'd255, 8'd255, 1'b0);
    send_point(8'd128, 8'd64, 1'b0);
    send_point(8'd254, 8'd254, 1'b0);
    set_shape(16'd0, 16'd2, 16'd2);
    send_point(8'd0, 8'd0, 1'b0);
    send_point(8'd1, 8'd1, 1'b0);
    send_point(8'hAA, 8'h55, 1'b0);
  endtask

  task automatic test_count_clamping();
    set_shape(16'd256, 16'd0, 16'd1);
    send_point(8'd0, 8'd1, 1'b0);
    send_point(8'd3, 8'd2, 1'b0);
    set_shape(16'd300, 16'h01FF, 16'd257);
    send_point(8'd255, 8'd200, 1'b0);
    drain();
    write_reg(REG_SPARE, 16'h1234);
    send_point(8'd17, 8'd33, 1'b0);
  endtask

  task automatic test_random_points(int count);
    int n;
    logic [8:0] rings, sectors;
    n = 0;
    while (n < count) begin
      rings = (n % 300 == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(2, 40));
      sectors = (n % 300 == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(2, 40));
      set_shape(16'($urandom), {7'd0, rings}, {7'd0, sectors});
      repeat (100) begin
        if ($urandom_range(0, 9) == 0)
          send_point(8'($urandom), 8'($urandom), 1'b1);
        else
          send_point(8'($urandom_range(0, rings)), 8'($urandom_range(0, sectors)), 1'b1);
        n++;
      end
    end
  endtask

  task automatic test_backpressure();
    set_shape(16'd512, 16'd32, 16'd32);
    hold_off = 1'b1;
    for (int k = 0; k < 60; k++) send_point(8'(k % 32), 8'(k * 7 % 32), 1'b0);
  endtask

  always @(posedge clk_i) begin
    if (hold_off) begin
      out_ready_i <= 1'b0;
      repeat (200) @(posedge clk_i);
      hold_off = 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    vertex_t want, got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{pos_x_o, pos_y_o, pos_z_o, norm_x_o, norm_y_o, norm_z_o,
              tex_u_o, tex_v_o, quad_base_o, quad_valid_o};
      got_items++;
      if (pending_vertices.size() == 0) begin
        $display("%0t: unexpected vertex %h", $time, got);
        errors++;
      end else begin
        want = pending_vertices.pop_front();
        if (got !== want) begin
          $display("%0t: vertex mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  initial begin
    radius_q88 = 256;
    rings_cfg = 16;
    sectors_cfg = 16;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_grid();
    test_field_extremes();
    test_count_clamping();
    test_backpressure();
    test_random_points(1200);
    drain();
    if (pending_vertices.size() != 0) begin
      $display("%0t: %0d vertices never arrived", $time, pending_vertices.size());
      errors++;
    end
    $display("Sent %0d grid points over many radius and grid settings, checked %0d vertices.",
             sent_items, got_items);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
